// ----- hdl/bcle_pkg.sv -----
package bcle_pkg;

    localparam int COMMAND_WIDTH = 3;
    localparam int INPUT_WIDTH   = 32;
    localparam int STATUS_WIDTH  = 2;
    localparam int FIELD_WIDTH   = 5;

    typedef enum logic [COMMAND_WIDTH-1:0] {
        CMD_INSERT_FRONT  = 3'd0,
        CMD_INSERT_BACK   = 3'd1,
        CMD_INSERT_SORTED = 3'd2,
        CMD_REMOVE        = 3'd3,
        CMD_SEARCH        = 3'd4
    } command_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // compare controls, sampled by every cell when a transaction is taken
    typedef struct packed {
        logic load;
        logic front;
        logic sorted;
        logic insert;
        logic match;
    } cmp_ctl_t;

    // update controls for the apply cycle
    typedef struct packed {
        logic ins;
        logic del;
    } upd_ctl_t;

endpackage

// ----- hdl/bcle_req_if.sv -----
interface bcle_req_if;

    logic                                 valid;
    logic                                 ready;
    logic [bcle_pkg::COMMAND_WIDTH-1:0]   command;
    logic signed [bcle_pkg::INPUT_WIDTH-1:0] value;

    modport source (
        output valid,
        output command,
        output value,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  value,
        output ready
    );

endinterface

// ----- hdl/bcle_rsp_if.sv -----
interface bcle_rsp_if;

    logic                               valid;
    logic                               ready;
    logic [bcle_pkg::STATUS_WIDTH-1:0]  status;
    logic [bcle_pkg::FIELD_WIDTH-1:0]   position;
    logic [bcle_pkg::FIELD_WIDTH-1:0]   element_count;

    modport source (
        output valid,
        output status,
        output position,
        output element_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  position,
        input  element_count,
        output ready
    );

endinterface

// ----- hdl/bcle_cell.sv -----
module bcle_cell #(
    parameter int CELL_INDEX  = 0,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bcle_pkg::cmp_ctl_t            cmp,
    input  bcle_pkg::upd_ctl_t            upd,
    input  logic [COUNT_WIDTH-1:0]        count,
    input  logic signed [VALUE_WIDTH-1:0] probe,
    input  logic signed [VALUE_WIDTH-1:0] wr_val,
    input  logic signed [VALUE_WIDTH-1:0] left_val,
    input  logic signed [VALUE_WIDTH-1:0] right_val,
    input  logic                          before_in,
    output logic                          before_out,
    output logic                          first_out,
    output logic signed [VALUE_WIDTH-1:0] val_out
);

    localparam bit IS_HEAD = (CELL_INDEX == 0);

    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic                          hit_reg;
    logic                          hit_next;
    logic                          occupied;
    logic                          is_tail;
    logic                          gt;
    logic                          eq;
    logic                          order_hit;

    assign occupied = (COUNT_WIDTH'(CELL_INDEX) < count);
    assign is_tail  = (COUNT_WIDTH'(CELL_INDEX) == count);
    assign gt       = (val_reg > probe);
    assign eq       = (val_reg == probe);

    // head takes a strictly smaller value; later cells stop at the first not-less
    assign order_hit = IS_HEAD ? gt : (gt | eq);

    always_comb
    begin
        hit_next = (cmp.match  & occupied & eq)
                 | (cmp.sorted & occupied & order_hit)
                 | (cmp.front  & IS_HEAD)
                 | (cmp.insert & is_tail);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmp.load)
        begin
            hit_reg <= hit_next;
        end
    end

    assign first_out  = hit_reg & ~before_in;
    assign before_out = before_in | hit_reg;

    always_ff @(posedge clk)
    begin
        if (upd.ins)
        begin
            if (before_in)
            begin
                val_reg <= left_val;
            end
            else if (hit_reg)
            begin
                val_reg <= wr_val;
            end
        end
        else if (upd.del && before_out)
        begin
            val_reg <= right_val;
        end
    end

    assign val_out = val_reg;

endmodule

// ----- hdl/bounded_circular_list_engine.sv -----
// Result: a taken transaction waits in ST_APPLY and its result is registered
//   as it leaves ST_APPLY, which it does only once the previous result is read.
// One command at a time: the cells compare on acceptance and shift one place as
//   ST_APPLY is left, and the next command is taken only back in ST_IDLE.
// Reset (rst_n, async, active low) empties the list; cell contents are left as is.
module bounded_circular_list_engine #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bcle_req_if.sink   req,
    bcle_rsp_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    // FSM
    bcle_pkg::state_t state_reg;
    bcle_pkg::state_t state_next;

    // command held from acceptance to apply
    logic [bcle_pkg::COMMAND_WIDTH-1:0] cmd_reg;
    logic signed [VALUE_WIDTH-1:0]      key_reg;
    logic signed [VALUE_WIDTH-1:0]      probe;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result register
    logic                                rsp_valid_reg;
    logic [bcle_pkg::STATUS_WIDTH-1:0]   status_reg;
    logic [bcle_pkg::STATUS_WIDTH-1:0]   status_next;
    logic [bcle_pkg::FIELD_WIDTH-1:0]    position_reg;
    logic [bcle_pkg::FIELD_WIDTH-1:0]    position_next;

    logic                accept;
    logic                rsp_free;
    logic                apply;
    logic                full;
    logic                found;
    logic [CW-1:0]       hit_pos;
    bcle_pkg::cmp_ctl_t  cmp;
    bcle_pkg::upd_ctl_t  upd;

    // cell chain wiring
    logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic                          ahead    [CAPACITY+1];
    logic                          first    [CAPACITY];

    assign accept   = req.valid & req.ready;
    assign rsp_free = ~rsp_valid_reg | rsp.ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign found    = ahead[CAPACITY];

    // low VALUE_WIDTH bits of the operand, sign extended when the cells are wider
    assign probe = VALUE_WIDTH'(req.value);

    //------------------------------------------------------------------
    // next state
    //------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bcle_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bcle_pkg::ST_APPLY;
                end
            end
            bcle_pkg::ST_APPLY:
            begin
                if (rsp_free)
                begin
                    state_next = bcle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcle_pkg::ST_IDLE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // FSM outputs
    //------------------------------------------------------------------
    always_comb
    begin
        req.ready = 1'b0;
        apply     = 1'b0;
        case (state_reg)
            bcle_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            bcle_pkg::ST_APPLY:
            begin
                apply = rsp_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    //------------------------------------------------------------------
    // compare setup: every cell latches its hit flag on acceptance.
    // An insert also flags the cell just past the tail, so the append slot
    // is always found last in the priority chain.
    //------------------------------------------------------------------
    always_comb
    begin
        cmp        = '0;
        cmp.load   = accept;
        case (req.command)
            bcle_pkg::CMD_INSERT_FRONT:
            begin
                cmp.front  = 1'b1;
                cmp.insert = 1'b1;
            end
            bcle_pkg::CMD_INSERT_BACK:
            begin
                cmp.insert = 1'b1;
            end
            bcle_pkg::CMD_INSERT_SORTED:
            begin
                cmp.sorted = 1'b1;
                cmp.insert = 1'b1;
            end
            bcle_pkg::CMD_REMOVE, bcle_pkg::CMD_SEARCH:
            begin
                cmp.match = 1'b1;
            end
            default:
            begin
                cmp.insert = 1'b0;
            end
        endcase
    end

    //------------------------------------------------------------------
    // apply: status, position, count and the shift controls
    //------------------------------------------------------------------
    always_comb
    begin
        status_next   = bcle_pkg::STAT_DONE;
        position_next = '0;
        count_next    = count_reg;
        upd           = '0;
        case (cmd_reg)
            bcle_pkg::CMD_INSERT_FRONT, bcle_pkg::CMD_INSERT_BACK,
            bcle_pkg::CMD_INSERT_SORTED:
            begin
                if (full)
                begin
                    status_next = bcle_pkg::STAT_FULL;
                end
                else
                begin
                    position_next = bcle_pkg::FIELD_WIDTH'(hit_pos);
                    count_next    = count_reg + CW'(1);
                    upd.ins       = apply;
                end
            end
            bcle_pkg::CMD_REMOVE:
            begin
                if (found)
                begin
                    position_next = bcle_pkg::FIELD_WIDTH'(hit_pos);
                    count_next    = count_reg - CW'(1);
                    upd.del       = apply;
                end
                else
                begin
                    status_next = bcle_pkg::STAT_NOT_FOUND;
                end
            end
            bcle_pkg::CMD_SEARCH:
            begin
                if (found)
                begin
                    position_next = bcle_pkg::FIELD_WIDTH'(hit_pos);
                end
                else
                begin
                    status_next = bcle_pkg::STAT_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = bcle_pkg::STAT_DONE;
            end
        endcase
    end

    //------------------------------------------------------------------
    // cell row: priority passes front to back through ahead[]
    //------------------------------------------------------------------
    assign ahead[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bcle_cell #(
            .CELL_INDEX  (i),
            .VALUE_WIDTH (VALUE_WIDTH),
            .COUNT_WIDTH (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmp        (cmp),
            .upd        (upd),
            .count      (count_reg),
            .probe      (probe),
            .wr_val     (key_reg),
            .left_val   ((i == 0) ? key_reg : cell_val[(i == 0) ? 0 : i - 1]),
            .right_val  (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
            .before_in  (ahead[i]),
            .before_out (ahead[i+1]),
            .first_out  (first[i]),
            .val_out    (cell_val[i])
        );
    end

    // one-hot first hit to index
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first[i])
            begin
                hit_pos = hit_pos | CW'(i);
            end
        end
    end

    //------------------------------------------------------------------
    // registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bcle_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            key_reg <= probe;
        end
        if (apply)
        begin
            status_reg   <= status_next;
            position_reg <= position_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.position      = position_reg;
    assign rsp.element_count = bcle_pkg::FIELD_WIDTH'(count_reg);

endmodule
